// ----- sv/svpwm_inverse_park_duty_top_macros.svh -----
// Assertion helpers shared by the block's modules.
// Each expects clk and rst in scope.
`ifndef SVPWM_INVERSE_PARK_DUTY_TOP_MACROS_SVH
`define SVPWM_INVERSE_PARK_DUTY_TOP_MACROS_SVH

// same-cycle implication
`define SVPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/svpd_pkg.sv -----
package svpd_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int ANGLE_IN_W = 12;
  localparam int ANGLE_SHIFT = 16 - ANGLE_BITS;
  localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;

  localparam logic [15:0] PERIOD_RESET = 16'd4200;
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;

  localparam int AB_W = 33;  // alpha, beta
  localparam int T_W = 38;   // x, y, z
  localparam int D_W = 26;   // unclamped duties

  // accept edge to the edge that takes the result
  localparam int LATENCY = 14;

  // quarter-wave sine, Q1.15
  localparam logic [14:0] SIN_TAB [17] = '{
    15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12539, 15'd15446, 15'd18204,
    15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898, 15'd30273,
    15'd31356, 15'd32137, 15'd32609, 15'd32767
  };

  typedef enum logic [2:0] {
    SECT_ZERO = 3'd0,
    SECT_1    = 3'd1,
    SECT_2    = 3'd2,
    SECT_3    = 3'd3,
    SECT_4    = 3'd4,
    SECT_5    = 3'd5,
    SECT_6    = 3'd6
  } sector_t;

  typedef struct packed {
    logic signed [15:0] ud;
    logic signed [15:0] uq;
    logic signed [15:0] s;
    logic signed [15:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
  } ab_t;

  typedef struct packed {
    sector_t               sector;
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
  } xyz_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    sector_t     sector;
    logic        saturated;
  } result_t;

  // sign code {-sa-b > 0, sa-b > 0, b > 0} to sector; all-positive is impossible
  function automatic sector_t sect_map(input logic [2:0] n);
    sector_t r;
    unique case (n)
      3'd0: r = SECT_ZERO;
      3'd1: r = SECT_2;
      3'd2: r = SECT_6;
      3'd3: r = SECT_1;
      3'd4: r = SECT_4;
      3'd5: r = SECT_3;
      3'd6: r = SECT_5;
      3'd7: r = SECT_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/svpd_trig.sv -----
module svpd_trig import svpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    ud,
  input  logic signed [15:0]    uq,
  input  logic [ANGLE_IN_W-1:0] angle,
  output logic                  out_valid,
  output trig_t                 out
);

  typedef struct packed {
    logic        neg;
    logic [14:0] base;
    logic [11:0] delta;
    logic [9:0]  frac;
  } prep_t;

  // quadrant fold and table fetch for one 16-bit angle
  function automatic prep_t prep(input logic [15:0] a16);
    logic [14:0] pos;
    logic [4:0]  idx;
    prep_t       r;
    pos = a16[14] ? (15'h4000 - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};
    idx = pos[14:10];
    r.neg = a16[15];
    r.frac = pos[9:0];
    if (idx[4]) begin
      r.base = SIN_TAB[16];
      r.delta = '0;
    end else begin
      r.base = SIN_TAB[idx];
      r.delta = 12'(SIN_TAB[idx + 5'd1] - SIN_TAB[idx]);
    end
    return r;
  endfunction

  function automatic logic [15:0] interp(input prep_t p);
    logic [21:0] pr;
    logic [14:0] v;
    pr = 22'(p.delta) * 22'(p.frac);
    v = p.base + 15'(pr[21:10]);
    return p.neg ? (16'd0 - 16'(v)) : 16'(v);
  endfunction

  logic [15:0] a16_s;
  logic [15:0] a16_c;

  assign a16_s = 16'((32'(angle) & ANGLE_MASK) << ANGLE_SHIFT);
  assign a16_c = a16_s + 16'h4000;

  logic               vld_a;
  logic signed [15:0] ud_a;
  logic signed [15:0] uq_a;
  prep_t              ps_a;
  prep_t              pc_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a <= in_valid;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    ud_a <= ud;
    uq_a <= uq;
    ps_a <= prep(a16_s);
    pc_a <= prep(a16_c);
    out.ud <= ud_a;
    out.uq <= uq_a;
    out.s <= interp(ps_a);
    out.c <= interp(pc_a);
  end

endmodule

// ----- sv/svpd_park.sv -----
module svpd_park import svpd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  trig_t in,
  output logic  out_valid,
  output ab_t   out
);

  logic               vld1;
  logic signed [31:0] p_us;
  logic signed [31:0] p_dc;
  logic signed [31:0] p_uc;
  logic signed [31:0] p_ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1 <= in_valid;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    p_us <= in.uq * in.s;
    p_dc <= in.ud * in.c;
    p_uc <= in.uq * in.c;
    p_ds <= in.ud * in.s;
    out.alpha <= AB_W'(p_dc) - AB_W'(p_us);
    out.beta <= AB_W'(p_uc) + AB_W'(p_ds);
  end

endmodule

// ----- sv/svpd_xyz.sv -----
`include "svpwm_inverse_park_duty_top_macros.svh"

module svpd_xyz import svpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  ab_t         in,
  input  logic [15:0] period,
  output logic        out_valid,
  output xyz_t        out
);

  localparam int R_W = AB_W + 18;  // sqrt3 product
  localparam int S_W = R_W - 16;   // sqrt3 * alpha, sqrt3 * beta
  localparam int Y_W = S_W + 1;    // +-3*alpha + sb
  localparam int XP_W = S_W + 17;
  localparam int YP_W = Y_W + 17;

  // stage 1: sqrt3 products
  logic                   vld1;
  logic signed [AB_W-1:0] alpha1;
  logic signed [AB_W-1:0] beta1;
  logic signed [R_W-1:0]  sa_raw1;
  logic signed [R_W-1:0]  sb_raw1;
  // stage 2: truncated toward zero
  logic                   vld2;
  logic signed [AB_W-1:0] alpha2;
  logic signed [AB_W-1:0] beta2;
  logic signed [S_W-1:0]  sa2;
  logic signed [S_W-1:0]  sb2;
  // stage 3: sector, y and z sums
  logic                   vld3;
  sector_t                sec3;
  logic signed [S_W-1:0]  sb3;
  logic signed [Y_W-1:0]  ysum3;
  logic signed [Y_W-1:0]  zsum3;
  // stage 4: period products
  logic                   vld4;
  sector_t                sec4;
  logic signed [XP_W-1:0] xp4;
  logic signed [YP_W-1:0] yp4;
  logic signed [YP_W-1:0] zp4;

  logic [R_W-1:0]         sa_b;
  logic [R_W-1:0]         sb_b;
  logic signed [Y_W-1:0]  a3;
  logic signed [Y_W-1:0]  dif_p;
  logic signed [Y_W-1:0]  dif_n;
  logic [2:0]             ncode;
  logic signed [17:0]     per_s;
  logic [XP_W-1:0]        xb;
  logic [YP_W-1:0]        yb;
  logic [YP_W-1:0]        zb;

  always_comb begin
    sa_b = sa_raw1 + R_W'({16{sa_raw1[R_W-1]}});
    sb_b = sb_raw1 + R_W'({16{sb_raw1[R_W-1]}});
    a3 = Y_W'(alpha2) + (Y_W'(alpha2) <<< 1);
    dif_p = Y_W'(sa2) - Y_W'(beta2);
    dif_n = -Y_W'(sa2) - Y_W'(beta2);
    ncode = {dif_n > 0, dif_p > 0, beta2 > 0};
    per_s = $signed({2'b00, period});
    xb = xp4 + XP_W'({14{xp4[XP_W-1]}});
    yb = yp4 + YP_W'({15{yp4[YP_W-1]}});
    zb = zp4 + YP_W'({15{zp4[YP_W-1]}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      out_valid <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    alpha1 <= in.alpha;
    beta1 <= in.beta;
    sa_raw1 <= R_W'(in.alpha) * R_W'($signed({1'b0, SQRT3_Q16}));
    sb_raw1 <= R_W'(in.beta) * R_W'($signed({1'b0, SQRT3_Q16}));

    alpha2 <= alpha1;
    beta2 <= beta1;
    sa2 <= $signed(sa_b[R_W-1:16]);
    sb2 <= $signed(sb_b[R_W-1:16]);

    sec3 <= sect_map(ncode);
    sb3 <= sb2;
    ysum3 <= a3 + Y_W'(sb2);
    zsum3 <= Y_W'(sb2) - a3;

    sec4 <= sec3;
    xp4 <= XP_W'(sb3) * XP_W'(per_s);
    yp4 <= YP_W'(ysum3) * YP_W'(per_s);
    zp4 <= YP_W'(zsum3) * YP_W'(per_s);

    out.sector <= sec4;
    out.x <= $signed(xb[XP_W-1:14]);
    out.y <= $signed(yb[YP_W-1:15]);
    out.z <= $signed(zb[YP_W-1:15]);
  end

  // positive beta always sets a sign bit, so never the zero vector
  `SVPD_ASSERT_IMPL(a_beta_sector, vld3 && ($past(beta2) > 0), sec3 != SECT_ZERO, "zero sector with beta above zero")

endmodule

// ----- sv/svpd_duty.sv -----
`include "svpwm_inverse_park_duty_top_macros.svh"

module svpd_duty import svpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  xyz_t        in,
  input  logic [15:0] period,
  output logic        out_valid,
  output result_t     out
);

  localparam int TE_W = T_W + 1;
  localparam int N_W = T_W + 2;
  localparam int V_W = D_W + 18;

  function automatic logic [16:0] clamp(input logic signed [D_W-1:0] d,
                                        input logic [15:0] p);
    logic [16:0] r;
    priority if (d < 0) begin
      r = {1'b1, 16'd0};
    end else if (d > D_W'($signed({1'b0, p}))) begin
      r = {1'b1, p};
    end else begin
      r = {1'b0, d[15:0]};
    end
    return r;
  endfunction

  // stage 1: pick on-times
  logic                   vld1;
  sector_t                sec1;
  logic signed [TE_W-1:0] t1_1;
  logic signed [TE_W-1:0] t2_1;
  logic signed [N_W-1:0]  tsum1;
  // stage 2: first duty
  logic                   vld2;
  sector_t                sec2;
  logic signed [TE_W-1:0] t1_2;
  logic signed [TE_W-1:0] t2_2;
  logic signed [D_W-1:0]  d0_2;
  // stage 3: second duty
  logic                   vld3;
  sector_t                sec3;
  logic signed [TE_W-1:0] t2_3;
  logic signed [D_W-1:0]  d0_3;
  logic signed [D_W-1:0]  d1_3;
  // stage 4: third duty
  logic                   vld4;
  sector_t                sec4;
  logic signed [D_W-1:0]  d0_4;
  logic signed [D_W-1:0]  d1_4;
  logic signed [D_W-1:0]  d2_4;

  logic signed [TE_W-1:0] xe;
  logic signed [TE_W-1:0] ye;
  logic signed [TE_W-1:0] ze;
  logic signed [TE_W-1:0] t1_next;
  logic signed [TE_W-1:0] t2_next;
  logic signed [N_W-1:0]  num;
  logic [N_W-1:0]         num_b;
  logic signed [V_W-1:0]  v1;
  logic [V_W-1:0]         v1_b;
  logic signed [V_W-1:0]  v2;
  logic [V_W-1:0]         v2_b;
  logic [16:0]            c0;
  logic [16:0]            c1;
  logic [16:0]            c2;
  result_t                res_next;

  always_comb begin
    xe = TE_W'(in.x);
    ye = TE_W'(in.y);
    ze = TE_W'(in.z);
    unique case (in.sector)
      SECT_1: begin t1_next = -ze; t2_next = xe;  end
      SECT_2: begin t1_next = ze;  t2_next = ye;  end
      SECT_3: begin t1_next = xe;  t2_next = -ye; end
      SECT_4: begin t1_next = -xe; t2_next = ze;  end
      SECT_5: begin t1_next = -ye; t2_next = -ze; end
      SECT_6: begin t1_next = ye;  t2_next = -xe; end
      default: begin t1_next = '0; t2_next = '0; end
    endcase

    // (P * 2^16 - t1 - t2) / 2^17, toward zero
    num = N_W'($signed({1'b0, period, 16'h0})) - tsum1;
    num_b = num + N_W'({17{num[N_W-1]}});

    v1 = V_W'($signed({d0_2, 16'h0})) + V_W'(t1_2);
    v1_b = v1 + V_W'({16{v1[V_W-1]}});
    v2 = V_W'($signed({d1_3, 16'h0})) + V_W'(t2_3);
    v2_b = v2 + V_W'({16{v2[V_W-1]}});

    c0 = clamp(d0_4, period);
    c1 = clamp(d1_4, period);
    c2 = clamp(d2_4, period);

    res_next.sector = sec4;
    res_next.saturated = c0[16] | c1[16] | c2[16];
    unique case (sec4)
      SECT_1: begin
        res_next.duty_a = c0[15:0]; res_next.duty_b = c1[15:0]; res_next.duty_c = c2[15:0];
      end
      SECT_2: begin
        res_next.duty_b = c0[15:0]; res_next.duty_a = c1[15:0]; res_next.duty_c = c2[15:0];
      end
      SECT_3: begin
        res_next.duty_b = c0[15:0]; res_next.duty_c = c1[15:0]; res_next.duty_a = c2[15:0];
      end
      SECT_4: begin
        res_next.duty_c = c0[15:0]; res_next.duty_b = c1[15:0]; res_next.duty_a = c2[15:0];
      end
      SECT_5: begin
        res_next.duty_c = c0[15:0]; res_next.duty_a = c1[15:0]; res_next.duty_b = c2[15:0];
      end
      SECT_6: begin
        res_next.duty_a = c0[15:0]; res_next.duty_c = c1[15:0]; res_next.duty_b = c2[15:0];
      end
      default: begin
        // zero vector: half period everywhere
        res_next.duty_a = period >> 1;
        res_next.duty_b = period >> 1;
        res_next.duty_c = period >> 1;
        res_next.sector = SECT_ZERO;
        res_next.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      out_valid <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    sec1 <= in.sector;
    t1_1 <= t1_next;
    t2_1 <= t2_next;
    tsum1 <= N_W'(t1_next) + N_W'(t2_next);

    sec2 <= sec1;
    t1_2 <= t1_1;
    t2_2 <= t2_1;
    d0_2 <= D_W'($signed(num_b[N_W-1:17]));

    sec3 <= sec2;
    t2_3 <= t2_2;
    d0_3 <= d0_2;
    d1_3 <= $signed(v1_b[D_W+15:16]);

    sec4 <= sec3;
    d0_4 <= d0_3;
    d1_4 <= d1_3;
    d2_4 <= $signed(v2_b[D_W+15:16]);

    out <= res_next;
  end

  `SVPD_ASSERT_IMPL(a_zero_vec, out_valid && (out.sector == SECT_ZERO), !out.saturated && (out.duty_a == out.duty_b) && (out.duty_b == out.duty_c), "zero vector duties differ or flagged")
  `SVPD_ASSERT_IMPL(a_sat_sector, out_valid && out.saturated, out.sector != SECT_ZERO, "clamp flagged on zero vector")

endmodule

// ----- sv/svpwm_inverse_park_duty_top.sv -----
// Inverse Park transform and seven-segment space vector PWM duty generator.
// Input beat: ud, uq (Q1.15 fractions of the DC bus) and elec_angle, taken at
// a rising edge with start high and busy low. busy is high only during reset,
// so a new item may be started in every cycle.
// Result beat: duty_a/b/c, sector and saturated are valid for the one cycle in
// which done is high. The receiver has no back-pressure; results are dropped
// onto the ports in input order, one per accepted item.
// done is high once the item has passed all the pipeline stages; no stall can delay it.
// Throughput: one item per clock, set by the 14-stage pipeline (2 sine/cosine,
// 2 rotation, 5 sqrt3/sector/period scaling, 5 duty and clamp stages).
// Configuration: pwm_period is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while no item is in flight.
// Reset (synchronous, rst high) empties the pipeline and sets pwm_period to
// 4200; items in flight are discarded.
// Duties are clamped to 0..pwm_period, saturated marks a clamp; the zero
// vector gives half-period duties with sector 0.
`include "svpwm_inverse_park_duty_top_macros.svh"

module svpwm_inverse_park_duty_top import svpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    ud,
  input  logic signed [15:0]    uq,
  input  logic [ANGLE_IN_W-1:0] elec_angle,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  output logic                  done,
  output logic [15:0]           duty_a,
  output logic [15:0]           duty_b,
  output logic [15:0]           duty_c,
  output logic [2:0]            sector,
  output logic                  saturated
);

  logic [15:0] pwm_period;
  logic        trig_vld;
  trig_t       trig;
  logic        ab_vld;
  ab_t         ab;
  logic        xyz_vld;
  xyz_t        xyz;
  result_t     res;

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pwm_period <= cfg_data;
    end
  end

  svpd_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .ud        (ud),
    .uq        (uq),
    .angle     (elec_angle),
    .out_valid (trig_vld),
    .out       (trig)
  );

  svpd_park u_park (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_vld),
    .in        (trig),
    .out_valid (ab_vld),
    .out       (ab)
  );

  svpd_xyz u_xyz (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ab_vld),
    .in        (ab),
    .period    (pwm_period),
    .out_valid (xyz_vld),
    .out       (xyz)
  );

  svpd_duty u_duty (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xyz_vld),
    .in        (xyz),
    .period    (pwm_period),
    .out_valid (done),
    .out       (res)
  );

  assign duty_a = res.duty_a;
  assign duty_b = res.duty_b;
  assign duty_c = res.duty_c;
  assign sector = res.sector;
  assign saturated = res.saturated;

  `SVPD_ASSERT_IMPL(a_latency, done, $past(start && !busy, LATENCY), "result without a matching start")
  `SVPD_ASSERT_NEXT(a_cfg_write, cfg_valid, pwm_period == $past(cfg_data), "period register missed a write")

endmodule
